// ===== rtl/sfa_pkg.sv =====
// Shared types and constants for the stochastic automaton step block.
// Used by the controller, the datapath and the top level.
package sfa_pkg;

    // Default sizes of the transition table.
    localparam int MAX_STATES_DEF      = 64;
    localparam int SLOTS_PER_STATE_DEF = 8;
    localparam int SYMBOL_BITS_DEF     = 8;

    // Widths of the configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Input request commands. Code 3 has no meaning and only reports the state.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_FORCE = 2'd2
    } sfa_command_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NUM_STATES      = 1'b0,
        CFG_FAIL_THRESHOLD  = 1'b1
    } sfa_cfg_index_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_FINISH
    } sfa_state_t;

    // One input request.
    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  state_index;
        logic [2:0]  slot;
        logic        entry_valid;
        logic [7:0]  entry_symbol;
        logic [5:0]  entry_destination;
        logic [15:0] entry_threshold;
        logic        entry_unconditional;
        logic [7:0]  input_symbol;
        logic [15:0] failure_draw;
        logic [15:0] select_draw;
        logic [15:0] jump_draw;
    } sfa_item_t;

    // One result.
    typedef struct packed {
        logic [5:0] new_state;
        logic       jumped;
        logic       no_match;
        logic [2:0] used_slot;
    } sfa_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic decide;
        logic scan;
        logic finish;
    } sfa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic needs_scan;
        logic scan_done;
    } sfa_status_t;

endpackage

// ===== rtl/sfa_if.sv =====
// Valid/ready channel interfaces for input requests and results.
// Depends on nothing but the standard types; payload widths are fixed.
interface sfa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [5:0]  state_index;
    logic [2:0]  slot;
    logic        entry_valid;
    logic [7:0]  entry_symbol;
    logic [5:0]  entry_destination;
    logic [15:0] entry_threshold;
    logic        entry_unconditional;
    logic [7:0]  input_symbol;
    logic [15:0] failure_draw;
    logic [15:0] select_draw;
    logic [15:0] jump_draw;

    modport source (
        output valid, command, state_index, slot, entry_valid, entry_symbol,
               entry_destination, entry_threshold, entry_unconditional,
               input_symbol, failure_draw, select_draw, jump_draw,
        input  ready
    );
    modport sink (
        input  valid, command, state_index, slot, entry_valid, entry_symbol,
               entry_destination, entry_threshold, entry_unconditional,
               input_symbol, failure_draw, select_draw, jump_draw,
        output ready
    );
endinterface

interface sfa_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] new_state;
    logic       jumped;
    logic       no_match;
    logic [2:0] used_slot;

    modport source (
        output valid, new_state, jumped, no_match, used_slot,
        input  ready
    );
    modport sink (
        input  valid, new_state, jumped, no_match, used_slot,
        output ready
    );
endinterface

// ===== rtl/sfa_ctrl.sv =====
// Controller state machine of the stochastic automaton step block.
// Depends on sfa_pkg for the state, command and status types.
module sfa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  sfa_pkg::sfa_status_t status,
    output sfa_pkg::sfa_cmd_t   cmd
);

    sfa_pkg::sfa_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfa_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            sfa_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = sfa_pkg::ST_IDLE;
                end
            end
            sfa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sfa_pkg::ST_DECIDE;
                end
            end
            sfa_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.needs_scan ? sfa_pkg::ST_SCAN : sfa_pkg::ST_FINISH;
            end
            sfa_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = sfa_pkg::ST_FINISH;
                end
            end
            sfa_pkg::ST_FINISH:
            begin
                // The result moves to the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = sfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfa_pkg::ST_IDLE;
            end
        endcase
    end

    // The output register holds a result until it is taken.
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/sfa_datapath.sv =====
// Datapath of the stochastic automaton step block: transition memory,
// configuration, current state, slot scan and result registers. Depends on sfa_pkg.
module sfa_datapath #(
    parameter int MAX_STATES      = sfa_pkg::MAX_STATES_DEF,
    parameter int SLOTS_PER_STATE = sfa_pkg::SLOTS_PER_STATE_DEF,
    parameter int SYMBOL_BITS     = sfa_pkg::SYMBOL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  sfa_pkg::sfa_item_t                item,
    input  sfa_pkg::sfa_cmd_t                 cmd,
    output sfa_pkg::sfa_status_t              status,
    output sfa_pkg::sfa_result_t              result
);

    localparam int DEPTH     = MAX_STATES * SLOTS_PER_STATE;
    localparam int AW        = $clog2(DEPTH);
    localparam int SW        = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
    localparam int WW        = SYMBOL_BITS + 24;
    localparam int JUMP_CAP  = (MAX_STATES < 64) ? MAX_STATES : 64;
    // Word layout: valid, symbol, destination, threshold, unconditional.
    localparam int POS_UNC   = 0;
    localparam int POS_THR   = 1;
    localparam int POS_DST   = 17;
    localparam int POS_SYM   = 23;
    localparam int POS_VLD   = WW - 1;

    localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS_PER_STATE - 1);

    logic [WW-1:0]       mem [DEPTH];
    logic [WW-1:0]       rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WW-1:0]       mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    sfa_pkg::sfa_item_t  item_reg;
    logic [5:0]          cur_state_reg;
    logic [6:0]          num_states_reg;
    logic [15:0]         fail_thr_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [SW-1:0]       scan_idx_reg;
    logic                found_reg;
    logic [SW-1:0]       pick_reg;
    logic [5:0]          pick_dest_reg;
    logic                res_jumped_reg;
    logic                res_no_match_reg;
    logic [2:0]          res_used_reg;
    sfa_pkg::sfa_result_t result_reg;

    logic                load_in_range;
    logic [AW-1:0]       load_addr;
    logic [AW-1:0]       row_base;
    logic                row_ok;
    logic                fail_hit;
    logic [6:0]          n_sat;
    logic [22:0]         jump_prod;
    logic [5:0]          jump_state;
    logic                is_load;
    logic                is_step;
    logic                is_force;

    logic                ent_valid;
    logic [SYMBOL_BITS-1:0] ent_symbol;
    logic [5:0]          ent_dest;
    logic [15:0]         ent_thr;
    logic                ent_unc;
    logic                hit;
    logic                stop;
    logic                scan_last;
    logic                scan_done;
    logic                found_now;

    // Decode of the captured request.
    assign is_load  = (item_reg.command == sfa_pkg::CMD_LOAD);
    assign is_step  = (item_reg.command == sfa_pkg::CMD_STEP);
    assign is_force = (item_reg.command == sfa_pkg::CMD_FORCE);

    // Load address and range check.
    assign load_in_range = (32'(item_reg.state_index) < MAX_STATES) &&
                           (32'(item_reg.slot) < SLOTS_PER_STATE);
    assign load_addr = AW'(item_reg.state_index) * AW'(SLOTS_PER_STATE) + AW'(item_reg.slot);

    // Row of the current state.
    assign row_base = AW'(cur_state_reg) * AW'(SLOTS_PER_STATE);
    assign row_ok   = (32'(cur_state_reg) < MAX_STATES);

    // Failure jump: state count saturated, scaled by the jump draw.
    assign fail_hit = (item_reg.failure_draw <= fail_thr_reg);
    always_comb
    begin
        if (num_states_reg == 7'd0)
        begin
            n_sat = 7'd1;
        end
        else if (32'(num_states_reg) > JUMP_CAP)
        begin
            n_sat = 7'(JUMP_CAP);
        end
        else
        begin
            n_sat = num_states_reg;
        end
    end
    assign jump_prod  = 23'(n_sat) * 23'(item_reg.jump_draw);
    assign jump_state = jump_prod[21:16];

    // Fields of the slot read in the previous cycle.
    assign ent_valid  = rd_data_reg[POS_VLD];
    assign ent_symbol = rd_data_reg[POS_SYM +: SYMBOL_BITS];
    assign ent_dest   = rd_data_reg[POS_DST +: 6];
    assign ent_thr    = rd_data_reg[POS_THR +: 16];
    assign ent_unc    = rd_data_reg[POS_UNC];

    // Scan: the first valid slot with the symbol starts the walk, then every
    // valid slot is a candidate until the select draw or the unconditional mark stops it.
    assign hit       = ent_valid &&
                       (found_reg || (ent_symbol == SYMBOL_BITS'(item_reg.input_symbol)));
    assign stop      = hit && ((item_reg.select_draw <= ent_thr) || ent_unc);
    assign scan_last = (scan_idx_reg == SLOT_LAST);
    assign scan_done = stop || scan_last;
    assign found_now = found_reg || hit;

    // Status to the controller.
    assign status.clear_done = (clr_cnt_reg == CLR_LAST);
    assign status.needs_scan = is_step && !fail_hit && row_ok;
    assign status.scan_done  = scan_done;

    // Memory port selection.
    always_comb
    begin
        mem_we    = cmd.clear || (cmd.decide && is_load && load_in_range);
        mem_waddr = cmd.clear ? clr_cnt_reg : load_addr;
        mem_wdata = '0;
        if (!cmd.clear)
        begin
            mem_wdata[POS_VLD]                = item_reg.entry_valid;
            mem_wdata[POS_SYM +: SYMBOL_BITS] = SYMBOL_BITS'(item_reg.entry_symbol);
            mem_wdata[POS_DST +: 6]           = item_reg.entry_destination;
            mem_wdata[POS_THR +: 16]          = item_reg.entry_threshold;
            mem_wdata[POS_UNC]                = item_reg.entry_unconditional;
        end
        mem_re    = (cmd.decide && status.needs_scan) || (cmd.scan && !scan_last);
        mem_raddr = cmd.decide ? row_base : (row_base + AW'(scan_idx_reg) + AW'(1));
    end

    // Transition memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Control state: configuration, current state and clearing counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= 7'd1;
            fail_thr_reg   <= 16'd0;
            cur_state_reg  <= 6'd0;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    sfa_pkg::CFG_NUM_STATES:     num_states_reg <= cfg_data[6:0];
                    sfa_pkg::CFG_FAIL_THRESHOLD: fail_thr_reg   <= cfg_data;
                    default:                     fail_thr_reg   <= fail_thr_reg;
                endcase
            end
            if (cmd.clear && !status.clear_done)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.decide)
            begin
                if (is_force)
                begin
                    cur_state_reg <= item_reg.state_index;
                end
                else if (is_step && fail_hit)
                begin
                    cur_state_reg <= jump_state;
                end
            end
            else if (cmd.scan && scan_done && found_now)
            begin
                cur_state_reg <= hit ? ent_dest : pick_dest_reg;
            end
        end
    end

    // Request capture, scan progress and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.decide)
        begin
            scan_idx_reg     <= '0;
            found_reg        <= 1'b0;
            res_jumped_reg   <= is_step && fail_hit;
            res_no_match_reg <= is_step && !fail_hit && !row_ok;
            res_used_reg     <= 3'd0;
        end
        if (cmd.scan)
        begin
            if (hit)
            begin
                found_reg     <= 1'b1;
                pick_reg      <= scan_idx_reg;
                pick_dest_reg <= ent_dest;
            end
            if (!scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + SW'(1);
            end
            if (scan_done)
            begin
                res_jumped_reg   <= 1'b0;
                res_no_match_reg <= !found_now;
                if (!found_now)
                begin
                    res_used_reg <= 3'd0;
                end
                else if (hit)
                begin
                    res_used_reg <= 3'(scan_idx_reg);
                end
                else
                begin
                    res_used_reg <= 3'(pick_reg);
                end
            end
        end
        if (cmd.finish)
        begin
            result_reg.new_state <= cur_state_reg;
            result_reg.jumped    <= res_jumped_reg;
            result_reg.no_match  <= res_no_match_reg;
            result_reg.used_slot <= res_used_reg;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/stochastic_fsa_step.sv =====
// Probabilistic finite automaton step block. After reset the transition memory is
// cleared, one entry per cycle, over all MAX_STATES * SLOTS_PER_STATE entries;
// requests are held off meanwhile, configuration writes are taken at any
// time. A load, force, undefined command or failure jump goes from decide straight
// to finish. A normal step scans the slots of the current row in between, reading
// k slots from the transition memory, with k up to SLOTS_PER_STATE, one at a time
// through the single read port of that memory. A new request is accepted only after
// the last one is finished. A finished result waits in an output register, so the
// next request is accepted while it waits to be taken.
// Depends on sfa_pkg, sfa_if, sfa_ctrl and sfa_datapath.
module stochastic_fsa_step #(
    parameter int MAX_STATES      = sfa_pkg::MAX_STATES_DEF,
    parameter int SLOTS_PER_STATE = sfa_pkg::SLOTS_PER_STATE_DEF,
    parameter int SYMBOL_BITS     = sfa_pkg::SYMBOL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    sfa_in_if.sink                          in_chan,
    sfa_out_if.source                       out_chan
);

    sfa_pkg::sfa_cmd_t    cmd;
    sfa_pkg::sfa_status_t status;
    sfa_pkg::sfa_item_t   item;
    sfa_pkg::sfa_result_t result;

    // Gather the request payload.
    assign item.command             = in_chan.command;
    assign item.state_index         = in_chan.state_index;
    assign item.slot                = in_chan.slot;
    assign item.entry_valid         = in_chan.entry_valid;
    assign item.entry_symbol        = in_chan.entry_symbol;
    assign item.entry_destination   = in_chan.entry_destination;
    assign item.entry_threshold     = in_chan.entry_threshold;
    assign item.entry_unconditional = in_chan.entry_unconditional;
    assign item.input_symbol        = in_chan.input_symbol;
    assign item.failure_draw        = in_chan.failure_draw;
    assign item.select_draw         = in_chan.select_draw;
    assign item.jump_draw           = in_chan.jump_draw;

    sfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_chan.valid),
        .in_ready  (in_chan.ready),
        .out_ready (out_chan.ready),
        .out_valid (out_chan.valid),
        .status    (status),
        .cmd       (cmd)
    );

    sfa_datapath #(
        .MAX_STATES      (MAX_STATES),
        .SLOTS_PER_STATE (SLOTS_PER_STATE),
        .SYMBOL_BITS     (SYMBOL_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    // Drive the result payload.
    assign out_chan.new_state = result.new_state;
    assign out_chan.jumped    = result.jumped;
    assign out_chan.no_match  = result.no_match;
    assign out_chan.used_slot = result.used_slot;

    // A result is written only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_chan.valid || out_chan.ready))
    else $error("result written over a pending result");

    // No request is accepted while the memory is cleared or an item is in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_chan.ready |-> !(cmd.clear || cmd.decide || cmd.scan || cmd.finish))
    else $error("request accepted while busy");

    // An accepted request is decided in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_chan.valid && in_chan.ready) |=> cmd.decide)
    else $error("accepted request not decided");

    // A finished scan does not continue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && status.scan_done) |=> !cmd.scan)
    else $error("scan ran past its end");

endmodule

// ===== tb/sv/tb_stochastic_fsa_step.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the stochastic automaton step block: directed and random requests.
// Depends on sfa_pkg, the channel interfaces in sfa_if and the top level stochastic_fsa_step.

// One transition slot as the scoreboard keeps it.
typedef struct packed {
    logic        occupied;
    logic [7:0]  symbol;
    logic [5:0]  target;
    logic [15:0] bound;
    logic        unconditional;
} table_slot_t;

// Mirrors the transition table, the current state and the two registers, and
// keeps the outcomes still owed by the block in request order.
class transition_scoreboard;
    table_slot_t          slots [sfa_pkg::MAX_STATES_DEF * sfa_pkg::SLOTS_PER_STATE_DEF];
    logic [5:0]           state;
    logic [6:0]           state_count;
    logic [15:0]          fail_limit;
    sfa_pkg::sfa_result_t pending_outcomes [$];
    int                   errors;

    function new();
        foreach (slots[i])
            slots[i] = '0;
        state       = '0;
        state_count = 7'd1;
        fail_limit  = '0;
        errors      = 0;
    endfunction

    function void set_register(sfa_pkg::sfa_cfg_index_t index, logic [15:0] data);
        if (index == sfa_pkg::CFG_NUM_STATES)
            state_count = data[6:0];
        else
            fail_limit = data;
    endfunction

    // Apply one accepted request and queue the outcome it must produce.
    function void note_request(sfa_pkg::sfa_item_t req);
        sfa_pkg::sfa_result_t outcome;
        int unsigned          span;
        int unsigned          product;
        int unsigned          base;
        int unsigned          first;
        int unsigned          pick;
        int unsigned          i;
        bit                   found;
        outcome = '0;
        if (req.command == sfa_pkg::CMD_LOAD) begin
            slots[req.state_index * sfa_pkg::SLOTS_PER_STATE_DEF + req.slot] =
                {req.entry_valid, req.entry_symbol, req.entry_destination,
                 req.entry_threshold, req.entry_unconditional};
        end
        else if (req.command == sfa_pkg::CMD_FORCE) begin
            state = req.state_index;
        end
        else if (req.command == sfa_pkg::CMD_STEP) begin
            if (req.failure_draw <= fail_limit) begin
                // Random jump, scaled by the state count held to 1..64.
                span = state_count;
                if (span < 1)
                    span = 1;
                if (span > sfa_pkg::MAX_STATES_DEF)
                    span = sfa_pkg::MAX_STATES_DEF;
                product = span * req.jump_draw;
                state = 6'(product >> 16);
                outcome.jumped = 1'b1;
            end
            else begin
                // First valid slot with the symbol opens the walk.
                base  = state * sfa_pkg::SLOTS_PER_STATE_DEF;
                found = 1'b0;
                first = 0;
                for (i = 0; i < sfa_pkg::SLOTS_PER_STATE_DEF; i++) begin
                    if (!found && slots[base + i].occupied
                        && slots[base + i].symbol == req.input_symbol) begin
                        found = 1'b1;
                        first = i;
                    end
                end
                if (!found) begin
                    outcome.no_match = 1'b1;
                end
                else begin
                    // Walk over valid slots; the last valid one is taken if none fits.
                    pick = first;
                    for (i = first; i < sfa_pkg::SLOTS_PER_STATE_DEF; i++) begin
                        if (slots[base + i].occupied) begin
                            pick = i;
                            if (req.select_draw <= slots[base + i].bound
                                || slots[base + i].unconditional)
                                break;
                        end
                    end
                    state = slots[base + pick].target;
                    outcome.used_slot = 3'(pick);
                end
            end
        end
        outcome.new_state = state;
        pending_outcomes.push_back(outcome);
    endfunction

    function void check_outcome(sfa_pkg::sfa_result_t got);
        sfa_pkg::sfa_result_t want;
        if (pending_outcomes.size() == 0) begin
            errors++;
            $error("result with no request outstanding: new_state %0d", got.new_state);
            return;
        end
        want = pending_outcomes.pop_front();
        if (got.new_state !== want.new_state) begin
            errors++;
            $error("new_state: expected %0d, got %0d", want.new_state, got.new_state);
        end
        if (got.jumped !== want.jumped) begin
            errors++;
            $error("jumped: expected %0d, got %0d", want.jumped, got.jumped);
        end
        if (got.no_match !== want.no_match) begin
            errors++;
            $error("no_match: expected %0d, got %0d", want.no_match, got.no_match);
        end
        if (got.used_slot !== want.used_slot) begin
            errors++;
            $error("used_slot: expected %0d, got %0d", want.used_slot, got.used_slot);
        end
    endfunction
endclass

module tb_stochastic_fsa_step;

    localparam logic [1:0] CMD_UNDEFINED   = 2'd3;
    localparam int         ACTIVE_SPAN     = 8;
    localparam int         PHASES          = 12;
    localparam int         PHASE_REQUESTS  = 108;
    localparam int         SETTLE_CYCLES   = 16;
    localparam int         WATCHDOG_LIMIT  = 4000;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [sfa_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sfa_pkg::CFG_DATA_W-1:0]  cfg_data;

    sfa_in_if  in_chan ();
    sfa_out_if out_chan ();

    transition_scoreboard sb;
    logic [7:0]           sym_pool [4];
    int                   burst_left;
    int                   stall_left;
    int                   stall_mode;
    int                   mode_left;
    int                   idle_cycles;

    stochastic_fsa_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (in_chan),
        .out_chan  (out_chan)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every field random; callers then fix the ones that matter.
    function automatic sfa_pkg::sfa_item_t random_fields();
        sfa_pkg::sfa_item_t r;
        r.command             = 2'($urandom());
        r.state_index         = 6'($urandom());
        r.slot                = 3'($urandom());
        r.entry_valid         = 1'($urandom());
        r.entry_symbol        = 8'($urandom());
        r.entry_destination   = 6'($urandom());
        r.entry_threshold     = 16'($urandom());
        r.entry_unconditional = 1'($urandom());
        r.input_symbol        = 8'($urandom());
        r.failure_draw        = 16'($urandom());
        r.select_draw         = 16'($urandom());
        r.jump_draw           = 16'($urandom());
        return r;
    endfunction

    function automatic sfa_pkg::sfa_item_t make_load(logic [5:0] st, logic [2:0] sl,
                                                     logic v, logic [7:0] sym,
                                                     logic [5:0] dst, logic [15:0] thr,
                                                     logic unc);
        sfa_pkg::sfa_item_t r;
        r = random_fields();
        r.command             = sfa_pkg::CMD_LOAD;
        r.state_index         = st;
        r.slot                = sl;
        r.entry_valid         = v;
        r.entry_symbol        = sym;
        r.entry_destination   = dst;
        r.entry_threshold     = thr;
        r.entry_unconditional = unc;
        return r;
    endfunction

    function automatic sfa_pkg::sfa_item_t make_step(logic [7:0] sym, logic [15:0] fail,
                                                     logic [15:0] sel, logic [15:0] jump);
        sfa_pkg::sfa_item_t r;
        r = random_fields();
        r.command      = sfa_pkg::CMD_STEP;
        r.input_symbol = sym;
        r.failure_draw = fail;
        r.select_draw  = sel;
        r.jump_draw    = jump;
        return r;
    endfunction

    function automatic sfa_pkg::sfa_item_t make_force(logic [5:0] st);
        sfa_pkg::sfa_item_t r;
        r = random_fields();
        r.command     = sfa_pkg::CMD_FORCE;
        r.state_index = st;
        return r;
    endfunction

    // Mostly loads and steps within a few states and symbols so that walks happen,
    // with some wide indexes, odd symbols, forces and undefined commands mixed in.
    function automatic sfa_pkg::sfa_item_t random_request();
        sfa_pkg::sfa_item_t r;
        int                 pick;
        r    = random_fields();
        pick = $urandom_range(99, 0);
        if (pick < 30) begin
            r.command = sfa_pkg::CMD_LOAD;
            if ($urandom_range(9, 0) != 0)
                r.state_index = 6'($urandom_range(ACTIVE_SPAN - 1, 0));
            r.entry_valid = 1'($urandom_range(6, 0) != 0);
            if ($urandom_range(6, 0) != 0)
                r.entry_symbol = sym_pool[$urandom_range(3, 0)];
            if ($urandom_range(9, 0) != 0)
                r.entry_destination = 6'($urandom_range(ACTIVE_SPAN - 1, 0));
            r.entry_unconditional = 1'($urandom_range(4, 0) == 0);
        end
        else if (pick < 90) begin
            r.command = sfa_pkg::CMD_STEP;
            if ($urandom_range(6, 0) != 0)
                r.input_symbol = sym_pool[$urandom_range(3, 0)];
        end
        else if (pick < 97) begin
            r.command = sfa_pkg::CMD_FORCE;
            if ($urandom_range(4, 0) != 0)
                r.state_index = 6'($urandom_range(ACTIVE_SPAN - 1, 0));
        end
        else begin
            r.command = CMD_UNDEFINED;
        end
        return r;
    endfunction

    task automatic put_fields(input sfa_pkg::sfa_item_t it);
        in_chan.command             <= it.command;
        in_chan.state_index         <= it.state_index;
        in_chan.slot                <= it.slot;
        in_chan.entry_valid         <= it.entry_valid;
        in_chan.entry_symbol        <= it.entry_symbol;
        in_chan.entry_destination   <= it.entry_destination;
        in_chan.entry_threshold     <= it.entry_threshold;
        in_chan.entry_unconditional <= it.entry_unconditional;
        in_chan.input_symbol        <= it.input_symbol;
        in_chan.failure_draw        <= it.failure_draw;
        in_chan.select_draw         <= it.select_draw;
        in_chan.jump_draw           <= it.jump_draw;
    endtask

    // Send one request; a new burst starts after a random gap.
    task automatic issue(input sfa_pkg::sfa_item_t it);
        if (burst_left == 0) begin
            in_chan.valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(120, 40)
                                                      : $urandom_range(10, 1);
        end
        burst_left--;
        put_fields(it);
        in_chan.valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_chan.ready);
    endtask

    // Drop valid and wait until every owed result has been taken and the block is quiet.
    // The first edge lets the monitor note the last accepted request.
    task automatic settle();
        in_chan.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending_outcomes.size() != 0 || out_chan.valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [6:0] count, input logic [15:0] limit);
        cfg_write <= 1'b1;
        cfg_index <= sfa_pkg::CFG_NUM_STATES;
        cfg_data  <= {9'd0, count};
        sb.set_register(sfa_pkg::CFG_NUM_STATES, {9'd0, count});
        @(posedge clk);
        cfg_index <= sfa_pkg::CFG_FAIL_THRESHOLD;
        cfg_data  <= limit;
        sb.set_register(sfa_pkg::CFG_FAIL_THRESHOLD, limit);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Result sink: stalls follow a randomly redrawn mode: no stalls, short stalls or long stalls.
    initial
    begin
        stall_left = 0;
        mode_left  = 0;
        stall_mode = 0;
        out_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0) begin
                stall_mode = $urandom_range(2, 0);
                mode_left  = $urandom_range(300, 50);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                out_chan.ready <= 1'b0;
            end
            else if (stall_mode == 1 && $urandom_range(3, 0) == 0) begin
                stall_left = $urandom_range(3, 0);
                out_chan.ready <= 1'b0;
            end
            else if (stall_mode == 2 && $urandom_range(7, 0) == 0) begin
                stall_left = $urandom_range(20, 4);
                out_chan.ready <= 1'b0;
            end
            else begin
                out_chan.ready <= 1'b1;
            end
        end
    end

    // Check results before noting requests, so a stray result never meets a fresh expectation.
    always @(posedge clk)
    begin
        sfa_pkg::sfa_result_t got;
        sfa_pkg::sfa_item_t   req;
        if (rst_n) begin
            if (out_chan.valid && out_chan.ready) begin
                got.new_state = out_chan.new_state;
                got.jumped    = out_chan.jumped;
                got.no_match  = out_chan.no_match;
                got.used_slot = out_chan.used_slot;
                sb.check_outcome(got);
            end
            if (in_chan.valid && in_chan.ready) begin
                req.command             = in_chan.command;
                req.state_index         = in_chan.state_index;
                req.slot                = in_chan.slot;
                req.entry_valid         = in_chan.entry_valid;
                req.entry_symbol        = in_chan.entry_symbol;
                req.entry_destination   = in_chan.entry_destination;
                req.entry_threshold     = in_chan.entry_threshold;
                req.entry_unconditional = in_chan.entry_unconditional;
                req.input_symbol        = in_chan.input_symbol;
                req.failure_draw        = in_chan.failure_draw;
                req.select_draw         = in_chan.select_draw;
                req.jump_draw           = in_chan.jump_draw;
                sb.note_request(req);
            end
        end
    end

    // Watchdog: too long without any handshake on either channel ends the run.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [6:0]  count;
        logic [15:0] limit;
        int          phase;
        sb = new();
        burst_left = 0;
        foreach (sym_pool[k])
            sym_pool[k] = 8'($urandom());
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= sfa_pkg::CFG_NUM_STATES;
        cfg_data  <= '0;
        in_chan.valid <= 1'b0;
        put_fields('0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: one state, jump only on a zero failure draw.
        issue(make_step(8'h5A, 16'hFFFF, 16'h0000, 16'h0000));   // empty table, no match
        issue(make_step(8'h5A, 16'h0000, 16'h0000, 16'hFFFF));   // jump, lands on state 0
        issue(make_load(6'd0, 3'd0, 1'b1, 8'h5A, 6'd3, 16'h1000, 1'b0));
        issue(make_load(6'd0, 3'd1, 1'b0, 8'hA5, 6'd63, 16'hFFFF, 1'b1));
        issue(make_load(6'd0, 3'd2, 1'b1, 8'h11, 6'd5, 16'h0000, 1'b0));
        issue(make_load(6'd0, 3'd7, 1'b1, 8'hFF, 6'd7, 16'h0000, 1'b0));
        issue(make_step(8'h5A, 16'hFFFF, 16'h0FFF, 16'h0000));   // first slot fits
        issue(make_force(6'd0));
        issue(make_step(8'h5A, 16'hFFFF, 16'h1001, 16'h0000));   // walk runs out at slot 7
        issue(make_load(6'd7, 3'd3, 1'b1, 8'h00, 6'd63, 16'hFFFF, 1'b0));
        issue(make_load(6'd7, 3'd4, 1'b1, 8'h22, 6'd1, 16'h0000, 1'b1));
        issue(make_step(8'h00, 16'hFFFF, 16'hFFFF, 16'h0000));   // draw equal to bound
        issue(make_force(6'd7));
        issue(make_load(6'd7, 3'd3, 1'b1, 8'h00, 6'd63, 16'h0000, 1'b0));
        issue(make_step(8'h00, 16'hFFFF, 16'hFFFF, 16'h0000));   // unconditional slot ends walk
        issue(make_step(8'hFF, 16'hFFFF, 16'h0000, 16'h0000));   // state 1 has no slots
        issue(make_load(6'd0, 3'd0, 1'b1, 8'h5A, 6'd3, 16'h1000, 1'b0) ^ '0);
        begin
            sfa_pkg::sfa_item_t odd;
            odd = random_fields();
            odd.command = CMD_UNDEFINED;
            issue(odd);
        end
        issue(make_force(6'd63));
        issue(make_step(8'h80, 16'hFFFF, 16'h0000, 16'h0000));
        issue(make_load(6'd63, 3'd7, 1'b1, 8'h80, 6'd0, 16'hFFFF, 1'b1));
        issue(make_step(8'h80, 16'hFFFF, 16'h0000, 16'h0000));   // highest state and slot
        issue(make_step(8'h80, 16'h0000, 16'h0000, 16'h0000));   // jump with zero draw
        issue(make_force(6'd0));
        issue(make_step(8'h11, 16'hFFFF, 16'h0000, 16'hFFFF));   // match skips earlier slot
        settle();

        // Random phases; the first few hold the register extremes.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin count = 7'd64;  limit = 16'hFFFF; end
                1: begin count = 7'd0;   limit = 16'h0000; end
                2: begin count = 7'd127; limit = 16'd2000; end
                3: begin count = 7'd1;   limit = 16'd20000; end
                default: begin
                    count = 7'($urandom_range(64, 1));
                    limit = 16'($urandom_range(6000, 0));
                end
            endcase
            apply_settings(count, limit);
            repeat (PHASE_REQUESTS) issue(random_request());
            settle();
        end

        if (sb.errors == 0 && sb.pending_outcomes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
